// ----- src/ssa_pkg.sv -----
`timescale 1ns / 1ps

package ssa_pkg;

  // Id space and field widths
  localparam int MAX_IDS = 1024;
  localparam int ID_W    = 10;
  localparam int CNT_W   = 11;

  // Request codes
  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;

  typedef struct packed {
    logic            action;
    logic            serializable;
    logic [ID_W-1:0] entity_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  id_out;
    logic [1:0]       status;
    logic [CNT_W-1:0] live_count;
  } rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // latch request, launch first memory reads
    logic rd_cur;    // capture slot/last, read dense at the slot
    logic wr_pop;    // create from free-list head
    logic wr_fresh;  // create from never-used id
    logic wr_swap;   // move last dense entry into freed slot
    logic wr_link;   // push deleted id onto free list
    logic err_full;
    logic err_dead;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic pop;
    logic del_bad;
    logic alive;
  } sts_t;

endpackage

// ----- src/ssa_ctrl.sv -----
`timescale 1ns / 1ps

module ssa_ctrl import ssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic action,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_C_EXEC,
    S_D_CUR,
    S_D_CHK,
    S_D_LINK
  } state_t;

  state_t state, state_next;
  logic   busy_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy_next  = busy;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          busy_next  = 1'b1;
          state_next = (action == ACT_CREATE) ? S_C_EXEC : S_D_CUR;
        end
      end
      S_C_EXEC: begin
        if (sts.full) begin
          cmd.err_full = 1'b1;
        end else if (sts.pop) begin
          cmd.wr_pop = 1'b1;
        end else begin
          cmd.wr_fresh = 1'b1;
        end
        busy_next  = 1'b0;
        state_next = S_IDLE;
      end
      S_D_CUR: begin
        if (sts.del_bad) begin
          cmd.err_dead = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_D_CHK;
        end
      end
      S_D_CHK: begin
        if (!sts.alive) begin
          cmd.err_dead = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
        end else begin
          cmd.wr_swap = 1'b1;
          state_next  = S_D_LINK;
        end
      end
      S_D_LINK: begin
        cmd.wr_link = 1'b1;
        busy_next   = 1'b0;
        state_next  = S_IDLE;
      end
      default: begin
        busy_next  = 1'b0;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
    end
  end

endmodule

// ----- src/ssa_datapath.sv -----
`timescale 1ns / 1ps

module ssa_datapath import ssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t request,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t result,
  output logic done
);

  logic [ID_W-1:0] sparse_mem [MAX_IDS];
  logic [ID_W-1:0] dense_mem  [MAX_IDS];

  req_t             req_q;
  logic [ID_W-1:0]  free_head;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] next_fresh;
  logic [ID_W-1:0]  sparse_rd;
  logic [ID_W-1:0]  dense_rd;
  logic [ID_W-1:0]  cur;
  logic [ID_W-1:0]  last;

  logic [CNT_W-1:0] fill_m1;
  logic [CNT_W-1:0] fill_p1;
  logic [ID_W-1:0]  sparse_raddr;
  logic [ID_W-1:0]  dense_raddr;
  logic [ID_W-1:0]  new_id;
  logic             sparse_we;
  logic [ID_W-1:0]  sparse_waddr;
  logic [ID_W-1:0]  sparse_wdata;
  logic             dense_we;
  logic [ID_W-1:0]  dense_waddr;
  logic [ID_W-1:0]  dense_wdata;

  assign fill_m1      = fill - CNT_W'(1);
  assign fill_p1      = fill + CNT_W'(1);
  assign sparse_raddr = (request.action == ACT_CREATE) ? free_head : request.entity_id;
  assign dense_raddr  = cmd.load ? fill_m1[ID_W-1:0] : sparse_rd;
  assign new_id       = cmd.wr_pop ? free_head : next_fresh[ID_W-1:0];

  always_comb begin
    sparse_we    = 1'b0;
    sparse_waddr = new_id;
    sparse_wdata = fill[ID_W-1:0];
    dense_we     = 1'b0;
    dense_waddr  = fill[ID_W-1:0];
    dense_wdata  = new_id;
    if (cmd.wr_pop || cmd.wr_fresh) begin
      sparse_we = 1'b1;
      dense_we  = 1'b1;
    end else if (cmd.wr_swap) begin
      sparse_we    = 1'b1;
      sparse_waddr = last;
      sparse_wdata = cur;
      dense_we     = 1'b1;
      dense_waddr  = cur;
      dense_wdata  = last;
    end else if (cmd.wr_link) begin
      // an empty free list leaves the link untouched
      sparse_we    = (free_count != '0);
      sparse_waddr = req_q.entity_id;
      sparse_wdata = free_head;
    end
  end

  // status
  assign sts.full    = (fill >= CNT_W'(MAX_IDS)) ||
                       ((free_count <= CNT_W'(1)) && (next_fresh >= CNT_W'(MAX_IDS)));
  assign sts.pop     = (free_count > CNT_W'(1));
  assign sts.del_bad = (CNT_W'(req_q.entity_id) >= CNT_W'(MAX_IDS)) ||
                       (CNT_W'(req_q.entity_id) >= next_fresh) || (fill == '0);
  // live iff its slot is in the dense range and points back at it
  assign sts.alive   = (CNT_W'(cur) < fill) && (dense_rd == req_q.entity_id);

  // memories
  always_ff @(posedge clk) begin
    if (sparse_we) begin
      sparse_mem[sparse_waddr] <= sparse_wdata;
    end
    if (dense_we) begin
      dense_mem[dense_waddr] <= dense_wdata;
    end
    if (cmd.load) begin
      sparse_rd <= sparse_mem[sparse_raddr];
    end
    if (cmd.load || cmd.rd_cur) begin
      dense_rd <= dense_mem[dense_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
    end
    if (cmd.rd_cur) begin
      cur  <= sparse_rd;
      last <= dense_rd;
    end
    if (cmd.wr_pop || cmd.wr_fresh) begin
      result <= '{id_out: new_id, status: ST_OK, live_count: fill_p1};
    end else if (cmd.wr_link) begin
      result <= '{id_out: req_q.entity_id, status: ST_OK, live_count: fill_m1};
    end else if (cmd.err_full) begin
      result <= '{id_out: '0, status: ST_FULL, live_count: fill};
    end else if (cmd.err_dead) begin
      result <= '{id_out: '0, status: ST_DEAD, live_count: fill};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_count <= '0;
      fill       <= '0;
      next_fresh <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.wr_pop | cmd.wr_fresh | cmd.wr_link | cmd.err_full | cmd.err_dead;
      if (cmd.wr_pop) begin
        free_head  <= sparse_rd;
        free_count <= free_count - CNT_W'(1);
        fill       <= fill_p1;
      end else if (cmd.wr_fresh) begin
        next_fresh <= next_fresh + CNT_W'(1);
        fill       <= fill_p1;
      end else if (cmd.wr_link) begin
        free_head  <= req_q.entity_id;
        free_count <= free_count + CNT_W'(1);
        fill       <= fill_m1;
      end
    end
  end

endmodule

// ----- src/sparse_set_id_allocator_top.sv -----
`timescale 1ns / 1ps

// Sparse-set id allocator. Pulse start with a request beat while busy is low:
// a create hands out a recycled id (only while more than one id sits on the
// free list, so one freed id is always held back) or the next never-used id;
// a delete retires a live id and pushes it onto the free list. Every request
// yields exactly one result beat, shown on result for one cycle with done
// high; the receiver cannot stall it, so capture it on that edge. A create
// passes one execute state; a delete passes the slot read, liveness check and
// free-list link, ending at the slot read when rejected early or at the check
// when the id is not live, following the chain of dependent reads of the
// single-ported sparse and dense memories. busy is high from the accepting
// edge until the result is registered, and a new request may be accepted in
// the same cycle its predecessor's result is shown. Status reports ok, full
// on a create with no id available, or dead on a delete of an id that is not
// live (id_out then reads zero). Liveness is derived from the sparse/dense
// cross-check, so no clearing pass follows reset; serializable goes unused.

module sparse_set_id_allocator_top import ssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one request at a time
  ssa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (request.action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // memories, free-list registers, result register
  ssa_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .done    (done)
  );

  // a result beat only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a request in flight");

  // the result register is never shown while a request is still in progress
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result beat while busy");

  // error beats carry a zero id
  a_err_zero_id: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.id_out == '0))
    else $error("error beat with nonzero id");

  // live count never exceeds the id space
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.live_count <= CNT_W'(MAX_IDS)))
    else $error("live count out of range");

endmodule
